// ----- src/hgrp_pkg.sv -----
// Shared types, constants and character tables for the HTTP GET request parser.
`default_nettype none

package hgrp_pkg;

   localparam int COUNT_BITS = 16;
   localparam int LIMIT_BITS = 16;
   localparam int CMP_BITS   = ((COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS) + 1;
   localparam int POS_BITS   = 4;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(4096);
   localparam logic [POS_BITS-1:0]   POS_MAX     = '1;
   localparam logic [POS_BITS-1:0]   METHOD_LEN  = POS_BITS'(3);
   localparam logic [POS_BITS-1:0]   VERSION_LEN = POS_BITS'(8);

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [2:0] {
      PH_METHOD  = 3'd0,
      PH_URL     = 3'd1,
      PH_VERSION = 3'd2,
      PH_HEADER  = 3'd3,
      PH_DONE    = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_PENDING = 2'd0,
      ST_BAD     = 2'd1,
      ST_ACCEPT  = 2'd2,
      ST_IGNORE  = 2'd3
   } status_type;

   typedef struct packed {
      phase_type              phase;
      logic [POS_BITS-1:0]    match_pos;
      logic                   mismatch;
      logic                   cr_seen;
      logic                   line_empty;
      logic [COUNT_BITS-1:0]  count;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{
      phase:      PH_METHOD,
      match_pos:  '0,
      mismatch:   1'b0,
      cr_seen:    1'b0,
      line_empty: 1'b1,
      count:      '0
   };

   typedef struct packed {
      status_type  status;
      logic [7:0]  url_byte;
      logic        url_valid;
   } result_type;

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      if (b >= 8'h41 && b <= 8'h5A) begin
         return b + 8'd32;
      end
      return b;
   endfunction

   // "get"; positions past the text never match anything that gets here
   function automatic logic [7:0] method_char(input logic [POS_BITS-1:0] pos);
      case (pos)
         4'd0:    return 8'h67;
         4'd1:    return 8'h65;
         4'd2:    return 8'h74;
         default: return 8'h00;
      endcase
   endfunction

   // "http/1.1"
   function automatic logic [7:0] version_char(input logic [POS_BITS-1:0] pos);
      case (pos)
         4'd0:    return 8'h68;
         4'd1:    return 8'h74;
         4'd2:    return 8'h74;
         4'd3:    return 8'h70;
         4'd4:    return 8'h2F;
         4'd5:    return 8'h31;
         4'd6:    return 8'h2E;
         4'd7:    return 8'h31;
         default: return 8'h00;
      endcase
   endfunction

endpackage

`default_nettype wire

// ----- src/hgrp_step.sv -----
// Next-state and result logic for one request byte.
`default_nettype none

module hgrp_step (
   input  wire logic [7:0]                     data_byte,
   input  wire logic                           end_of_stream,
   input  wire logic                           restart,
   input  wire logic [hgrp_pkg::LIMIT_BITS-1:0] max_request_bytes,
   input  var  hgrp_pkg::parse_state_type      state_cur,
   output      hgrp_pkg::parse_state_type      state_nxt,
   output      hgrp_pkg::result_type           result
);
   import hgrp_pkg::*;

   logic [CMP_BITS-1:0] count_next;
   logic [CMP_BITS-1:0] count_mask;
   logic [CMP_BITS-1:0] limit_ext;
   logic [7:0]          lower;
   status_type          status;
   logic                is_url;

   assign count_next = CMP_BITS'(state_cur.count) + CMP_BITS'(1);
   assign count_mask = CMP_BITS'({COUNT_BITS{1'b1}});
   assign limit_ext  = CMP_BITS'(max_request_bytes);
   assign lower      = to_lower(data_byte);

   always_comb begin
      state_nxt = state_cur;
      status    = ST_PENDING;
      is_url    = 1'b0;

      if (restart) begin
         state_nxt = PARSE_RESET;
      end else if (state_cur.phase == PH_DONE) begin
         status = ST_IGNORE;
      end else if (end_of_stream) begin
         status = ST_BAD;
      end else begin
         if (count_next > limit_ext || count_next > count_mask) begin
            status = ST_BAD;
         end else begin
            state_nxt.count = count_next[COUNT_BITS-1:0];
            if (state_cur.cr_seen) begin
               state_nxt.cr_seen = 1'b0;
               if (data_byte != CHAR_LF) begin
                  status = ST_BAD;
               end else if (state_cur.phase == PH_HEADER) begin
                  if (state_cur.line_empty) begin
                     status = ST_ACCEPT;
                  end else begin
                     state_nxt.line_empty = 1'b1;
                  end
               end else if (state_cur.phase == PH_VERSION && state_cur.match_pos == VERSION_LEN
                            && !state_cur.mismatch) begin
                  state_nxt.phase      = PH_HEADER;
                  state_nxt.match_pos  = '0;
                  state_nxt.line_empty = 1'b1;
               end else begin
                  status = ST_BAD;
               end
            end else if (data_byte == CHAR_CR) begin
               state_nxt.cr_seen = 1'b1;
            end else if (data_byte == CHAR_LF) begin
               status = ST_BAD;
            end else begin
               state_nxt.line_empty = 1'b0;
               case (state_cur.phase)
                  PH_METHOD: begin
                     if (data_byte == CHAR_SPACE) begin
                        if (state_cur.match_pos != METHOD_LEN || state_cur.mismatch) begin
                           status = ST_BAD;
                        end else begin
                           state_nxt.phase     = PH_URL;
                           state_nxt.match_pos = '0;
                        end
                     end else begin
                        if (state_cur.match_pos >= METHOD_LEN
                            || lower != method_char(state_cur.match_pos)) begin
                           state_nxt.mismatch = 1'b1;
                        end
                        if (state_cur.match_pos != POS_MAX) begin
                           state_nxt.match_pos = state_cur.match_pos + POS_BITS'(1);
                        end
                     end
                  end
                  PH_URL: begin
                     if (data_byte == CHAR_SPACE) begin
                        if (state_cur.match_pos == '0) begin
                           status = ST_BAD;
                        end else begin
                           state_nxt.phase     = PH_VERSION;
                           state_nxt.match_pos = '0;
                           state_nxt.mismatch  = 1'b0;
                        end
                     end else if (state_cur.match_pos == '0 && data_byte != CHAR_SLASH) begin
                        status = ST_BAD;
                     end else begin
                        state_nxt.match_pos = POS_BITS'(1);
                        is_url              = 1'b1;
                     end
                  end
                  PH_VERSION: begin
                     if (state_cur.match_pos >= VERSION_LEN
                         || lower != version_char(state_cur.match_pos)) begin
                        state_nxt.mismatch = 1'b1;
                     end
                     if (state_cur.match_pos != POS_MAX) begin
                        state_nxt.match_pos = state_cur.match_pos + POS_BITS'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         if (status == ST_BAD || status == ST_ACCEPT) begin
            state_nxt.phase = PH_DONE;
            is_url          = 1'b0;
         end
      end
   end

   assign result.status    = status;
   assign result.url_valid = is_url;
   assign result.url_byte  = is_url ? data_byte : 8'h00;

endmodule

`default_nettype wire

// ----- src/http_get_request_parser.sv -----
// Top level of the HTTP GET request parser: input register, parser state, result register.
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  data_byte, end_of_stream, restart
// rsp_      out        rsp_valid/rsp_stall  status, url_byte, url_valid
// csr_      in         csr_write_enable     csr_write_data (max_request_bytes)
//
// One byte per cycle while rsp_ is not stalled. A byte in the input register moves into
// the result register once that register can take it, and its result is then on rsp_
// (parser state is updated as it moves from the input register to the result register).
// Synchronous active-high reset clears the parser and sets the byte limit to 4096.
// A stall on rsp_ holds the result register and then backs up into the input register.

module http_get_request_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_stream,
   input  wire logic        req_restart,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_status,
   output      logic [7:0]  rsp_url_byte,
   output      logic        rsp_url_valid,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);
   import hgrp_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff, in_byte_in;
   logic                  in_eos_ff, in_eos_in;
   logic                  in_restart_ff, in_restart_in;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_result_ff, out_result_in;
   parse_state_type       state_ff, state_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;

   parse_state_type       state_calc;
   result_type            result_calc;
   logic                  out_ready;
   logic                  advance;
   logic                  req_take;

   hgrp_step u_step (
      .data_byte         (in_byte_ff),
      .end_of_stream     (in_eos_ff),
      .restart           (in_restart_ff),
      .max_request_bytes (limit_ff),
      .state_cur         (state_ff),
      .state_nxt         (state_calc),
      .result            (result_calc)
   );

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      in_eos_in     = in_eos_ff;
      in_restart_in = in_restart_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      if (req_take) begin
         in_byte_in    = req_data_byte;
         in_eos_in     = req_end_of_stream;
         in_restart_in = req_restart;
      end

      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      if (out_ready) begin
         out_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_result_in = result_calc;
      end

      state_in = advance ? state_calc : state_ff;
      limit_in = csr_write_enable ? csr_write_data : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= PARSE_RESET;
         limit_ff     <= LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         limit_ff     <= limit_in;
      end
      in_byte_ff    <= in_byte_in;
      in_eos_ff     <= in_eos_in;
      in_restart_ff <= in_restart_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_result_ff.status;
   assign rsp_url_byte  = out_result_ff.url_byte;
   assign rsp_url_valid = out_result_ff.url_valid;

endmodule

`default_nettype wire

// ----- tb/tb_http_get_request_parser.sv -----
// Self-checking testbench for the HTTP GET request parser: directed table, then random requests.
`timescale 1ns / 100ps

module tb_http_get_request_parser;
   import hgrp_pkg::*;

   typedef struct packed {
      logic [7:0] octet;
      logic       eos;
      logic       restart;
   } req_item_type;

   typedef struct packed {
      req_item_type item;
      logic         typed;
      result_type   verdict;
   } table_row_type;

   localparam result_type NO_CHECK = '{ST_PENDING, 8'h00, 1'b0};
   localparam logic [23:0] GET_WORD = "get";
   localparam logic [63:0] VERSION_WORD = "http/1.1";
   localparam int N_ROWS = 30;
   localparam int N_PHASES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_stream = 1'b0;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_url_byte;
   logic        rsp_url_valid;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = 16'h0000;

   // parser shadow state
   phase_type   cur_phase;
   logic [3:0]  tok_pos;
   logic        tok_bad;
   logic        cr_pending;
   logic        blank_line;
   logic [15:0] byte_count;
   logic [15:0] byte_limit;

   result_type   pending_verdicts[$];
   req_item_type request_bytes[$];
   bit           steady = 1'b0;
   int           errors = 0;
   int           sent_count = 0;
   int           live_count = 0;
   int           checked_count = 0;

   // directed stimulus: known verdicts typed in, the rest left to the shadow parser
   table_row_type directed_rows [N_ROWS] = '{
      '{'{8'h00, 1'b1, 1'b1}, 1'b1, '{ST_PENDING, 8'h00, 1'b0}},  // restart beats end of stream
      '{'{"G",   1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{"e",   1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{"T",   1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{" ",   1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{"/",   1'b0, 1'b0}, 1'b1, '{ST_PENDING, "/", 1'b1}},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b1, '{ST_PENDING, 8'hFF, 1'b1}},
      '{'{" ",   1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{"H",   1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{"t",   1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{"T",   1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{"p",   1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{"/",   1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{"1",   1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{".",   1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{"1",   1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{CHAR_CR, 1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{CHAR_LF, 1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{CHAR_CR, 1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{CHAR_LF, 1'b0, 1'b0}, 1'b1, '{ST_ACCEPT, 8'h00, 1'b0}},
      '{'{8'h00, 1'b1, 1'b0}, 1'b1, '{ST_IGNORE, 8'h00, 1'b0}},
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{ST_PENDING, 8'h00, 1'b0}},
      '{'{CHAR_LF, 1'b0, 1'b0}, 1'b1, '{ST_BAD, 8'h00, 1'b0}},    // bare LF
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{ST_PENDING, 8'h00, 1'b0}},
      '{'{8'h00, 1'b1, 1'b0}, 1'b1, '{ST_BAD, 8'h00, 1'b0}},      // stream closed early
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{ST_PENDING, 8'h00, 1'b0}},
      '{'{CHAR_CR, 1'b0, 1'b0}, 1'b0, NO_CHECK},
      '{'{"A",   1'b0, 1'b0}, 1'b1, '{ST_BAD, 8'h00, 1'b0}},      // CR without LF
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{ST_PENDING, 8'h00, 1'b0}},
      '{'{" ",   1'b0, 1'b0}, 1'b1, '{ST_BAD, 8'h00, 1'b0}}       // empty method
   };

   logic [15:0] phase_limits [N_PHASES] = '{16'd4096, 16'd65535, 16'd16, 16'd0, 16'd1,
                                            16'd37, 16'd4096, 16'd4096};
   int          phase_targets [N_PHASES] = '{110, 230, 330, 350, 370, 480, 620, 750};

   http_get_request_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_url_byte      (rsp_url_byte),
      .rsp_url_valid     (rsp_url_valid),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 30) begin
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   function automatic void clear_shadow();
      cur_phase = PH_METHOD;
      tok_pos = 4'd0;
      tok_bad = 1'b0;
      cr_pending = 1'b0;
      blank_line = 1'b1;
      byte_count = 16'd0;
   endfunction

   // CR LF just completed
   function automatic status_type close_line();
      if (cur_phase == PH_HEADER) begin
         if (blank_line) begin
            return ST_ACCEPT;
         end
         blank_line = 1'b1;
         return ST_PENDING;
      end
      if (cur_phase == PH_VERSION && tok_pos == 4'd8 && !tok_bad) begin
         cur_phase = PH_HEADER;
         tok_pos = 4'd0;
         blank_line = 1'b1;
         return ST_PENDING;
      end
      return ST_BAD;
   endfunction

   function automatic result_type parse_byte(input req_item_type it);
      result_type  r;
      status_type  st;
      logic        is_url;
      logic [16:0] next_count;
      logic [7:0]  c;
      logic [7:0]  lc;
      int          idx;
      st = ST_PENDING;
      is_url = 1'b0;
      c = it.octet;
      lc = (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
      idx = tok_pos;
      if (it.restart) begin
         clear_shadow();
      end else if (cur_phase == PH_DONE) begin
         st = ST_IGNORE;
      end else if (it.eos) begin
         st = ST_BAD;
      end else begin
         next_count = {1'b0, byte_count} + 17'd1;
         if (next_count > {1'b0, byte_limit} || next_count > 17'h0FFFF) begin
            st = ST_BAD;
         end else begin
            byte_count = next_count[15:0];
            if (cr_pending) begin
               cr_pending = 1'b0;
               st = (c == CHAR_LF) ? close_line() : ST_BAD;
            end else if (c == CHAR_CR) begin
               cr_pending = 1'b1;
            end else if (c == CHAR_LF) begin
               st = ST_BAD;
            end else begin
               blank_line = 1'b0;
               case (cur_phase)
                  PH_METHOD: begin
                     if (c == CHAR_SPACE) begin
                        if (tok_pos != 4'd3 || tok_bad) begin
                           st = ST_BAD;
                        end else begin
                           cur_phase = PH_URL;
                           tok_pos = 4'd0;
                        end
                     end else begin
                        if (idx >= 3) begin
                           tok_bad = 1'b1;
                        end else if (lc != GET_WORD[8*(2-idx) +: 8]) begin
                           tok_bad = 1'b1;
                        end
                        if (tok_pos < 4'd15) begin
                           tok_pos++;
                        end
                     end
                  end
                  PH_URL: begin
                     if (c == CHAR_SPACE) begin
                        if (tok_pos == 4'd0) begin
                           st = ST_BAD;
                        end else begin
                           cur_phase = PH_VERSION;
                           tok_pos = 4'd0;
                           tok_bad = 1'b0;
                        end
                     end else if (tok_pos == 4'd0 && c != CHAR_SLASH) begin
                        st = ST_BAD;
                     end else begin
                        tok_pos = 4'd1;
                        is_url = 1'b1;
                     end
                  end
                  PH_VERSION: begin
                     if (idx >= 8) begin
                        tok_bad = 1'b1;
                     end else if (lc != VERSION_WORD[8*(7-idx) +: 8]) begin
                        tok_bad = 1'b1;
                     end
                     if (tok_pos < 4'd15) begin
                        tok_pos++;
                     end
                  end
                  default: ;
               endcase
            end
         end
         if (st == ST_BAD || st == ST_ACCEPT) begin
            cur_phase = PH_DONE;
            is_url = 1'b0;
         end
      end
      r.status = st;
      r.url_valid = is_url;
      r.url_byte = is_url ? c : 8'h00;
      return r;
   endfunction

   function automatic logic [7:0] random_case(input logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) begin
         return c - 8'd32;
      end
      return c;
   endfunction

   function automatic logic [7:0] text_byte(input bit allow_space);
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (c == CHAR_CR || c == CHAR_LF || (!allow_space && c == CHAR_SPACE));
      return c;
   endfunction

   function automatic void push_byte(input logic [7:0] c);
      request_bytes.push_back('{octet: c, eos: 1'b0, restart: 1'b0});
   endfunction

   function automatic void push_line_end();
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
   endfunction

   function automatic logic [7:0] tricky_byte();
      case ($urandom_range(0, 4))
         0: return CHAR_SPACE;
         1: return CHAR_CR;
         2: return CHAR_LF;
         3: return CHAR_SLASH;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one request: mostly well formed with random content, some damaged, some pure noise
   function automatic void compose_request();
      int           kind;
      int           n;
      int           k;
      req_item_type it;
      request_bytes.delete();
      request_bytes.push_back('{octet: 8'($urandom_range(0, 255)), eos: 1'b0, restart: 1'b1});
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         n = $urandom_range(1, 20);
         repeat (n) begin
            it.octet = ($urandom_range(0, 3) == 0) ? tricky_byte() : 8'($urandom_range(0, 255));
            it.eos = ($urandom_range(0, 7) == 0);
            it.restart = ($urandom_range(0, 7) == 0);
            request_bytes.push_back(it);
         end
         return;
      end
      for (int i = 2; i >= 0; i--) begin
         push_byte(random_case(GET_WORD[8*i +: 8]));
      end
      push_byte(CHAR_SPACE);
      push_byte(CHAR_SLASH);
      n = $urandom_range(0, 8);
      repeat (n) push_byte(text_byte(1'b0));
      push_byte(CHAR_SPACE);
      for (int i = 7; i >= 0; i--) begin
         push_byte(random_case(VERSION_WORD[8*i +: 8]));
      end
      push_line_end();
      repeat ($urandom_range(0, 3)) begin
         n = $urandom_range(0, 12);
         repeat (n) push_byte(text_byte(1'b1));
         push_line_end();
      end
      push_line_end();
      if (kind <= 3) begin
         k = $urandom_range(1, request_bytes.size() - 1);
         case ($urandom_range(0, 3))
            0: request_bytes[k].octet = tricky_byte();
            1: request_bytes.delete(k);
            2: request_bytes.insert(k, '{octet: tricky_byte(), eos: 1'b0, restart: 1'b0});
            default: begin
               while (request_bytes.size() > k) begin
                  void'(request_bytes.pop_back());
               end
               request_bytes.push_back('{octet: 8'h00, eos: 1'b1, restart: 1'b0});
            end
         endcase
      end
      // trailing bytes after the verdict are ignored
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) begin
         request_bytes.push_back('{octet: 8'($urandom_range(0, 255)), eos: 1'b1, restart: 1'b0});
      end
      if ($urandom_range(0, 7) == 0) begin
         steady = !steady;
      end
   endfunction

   task automatic send_item(input req_item_type it, input logic typed, input result_type known);
      int         gap;
      result_type want;
      gap = steady ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_data_byte <= it.octet;
      req_end_of_stream <= it.eos;
      req_restart <= it.restart;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      want = parse_byte(it);
      if (typed) begin
         want = known;
      end
      pending_verdicts.push_back(want);
      sent_count++;
      if (want.status != ST_IGNORE) begin
         live_count++;
      end
   endtask

   task automatic drain_verdicts();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      drain_verdicts();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      byte_limit = value;
   endtask

   // result side: a random stall (none in steady mode) ahead of each transaction
   initial begin
      int n;
      forever begin
         n = steady ? 0 : $urandom_range(0, 18);
         if (n > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction: status %0d url %0b/%02h",
                                      rsp_status, rsp_url_valid, rsp_url_byte));
         end else begin
            want = pending_verdicts.pop_front();
            checked_count++;
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            end
            if (rsp_url_valid !== want.url_valid) begin
               report_mismatch($sformatf("url_valid %0b, expected %0b",
                                         rsp_url_valid, want.url_valid));
            end
            if (rsp_url_byte !== want.url_byte) begin
               report_mismatch($sformatf("url_byte %02h, expected %02h",
                                         rsp_url_byte, want.url_byte));
            end
         end
      end
   end

   initial begin
      #1_000_000;
      $display("http_get_request_parser test failed");
      $finish;
   end

   initial begin
      byte_limit = LIMIT_RESET;
      clear_shadow();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_ROWS; i++) begin
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].verdict);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         if (p > 0) begin
            write_limit(p == N_PHASES - 1 ? 16'($urandom_range(16, 120)) : phase_limits[p]);
         end
         while (sent_count < phase_targets[p]) begin
            compose_request();
            foreach (request_bytes[i]) begin
               send_item(request_bytes[i], 1'b0, NO_CHECK);
            end
         end
      end

      drain_verdicts();
      repeat (8) @(posedge clock);
      $display("%0d byte transactions sent (%0d not ignored), %0d results checked",
               sent_count, live_count, checked_count);
      $display("byte limits covered: reset value, 0, 1, 16, 37, 65535 and one random");
      if (errors == 0 && pending_verdicts.size() == 0) begin
         $display("http_get_request_parser test passed");
      end else begin
         $display("http_get_request_parser test failed");
      end
      $finish;
   end

endmodule
